// ===== hw/rtl/selu_pkg.sv =====
// ----------------------------------------------------------------------------
// selu_pkg: shared types and constants for the sequenced event ring log
// Holds the log geometry, command and result codes, and the word formats that
// travel between the front (accept and classify) and back (execute) parts.
// ----------------------------------------------------------------------------
package selu_pkg;

  // Log geometry
  localparam int LOG_DEPTH = 32;
  localparam int IDX_W     = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int CNT_W     = $clog2(LOG_DEPTH + 1);
  localparam int SUM_W     = CNT_W + 1;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Field widths
  localparam int SEQ_W  = 32;
  localparam int TIME_W = 32;
  localparam int TAG_W  = 11;
  localparam int MAXE_W = 7;

  // Function codes on the input channel
  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  // Largest legal event codes
  localparam logic [2:0] ACTOR_MAX   = 3'd3;
  localparam logic [2:0] CHANNEL_MAX = 3'd6;
  localparam logic [3:0] PHASE_MAX   = 4'd8;

  // Classified command kinds
  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_READ   = 2'd2
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_APPENDED = 2'd0,
    STATUS_REJECTED = 2'd1,
    STATUS_EVENT    = 2'd2,
    STATUS_NONE     = 2'd3
  } status_t;

  // Command word from front to back
  typedef struct packed {
    kind_t               kind;
    logic [TIME_W-1:0]   time_ms;
    logic [TAG_W-1:0]    tag;     // {background, redacted, phase, channel, actor}
    logic [SEQ_W-1:0]    seq_floor;
    logic [MAXE_W-1:0]   max_events;
  } cmd_t;

  // One stored log entry
  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] time_ms;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  // One result word
  typedef struct packed {
    status_t          status;
    entry_t           ent;
    logic [SEQ_W-1:0] newest;
    logic             lost;
    logic             last;
    logic [31:0]      dropped;
  } result_t;

  function automatic result_t make_result(
    input status_t          status,
    input entry_t           ent,
    input logic [SEQ_W-1:0] newest,
    input logic             lost,
    input logic             last,
    input logic [31:0]      dropped
  );
    result_t r;
    r.status  = status;
    r.ent     = ent;
    r.newest  = newest;
    r.lost    = lost;
    r.last    = last;
    r.dropped = dropped;
    return r;
  endfunction

endpackage

// ===== hw/rtl/selu_front.sv =====
// ----------------------------------------------------------------------------
// selu_front: command intake
// Accepts input words, checks the event codes, packs the tag and queues the
// classified command for the back part in a short FIFO.
// ----------------------------------------------------------------------------
module selu_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_func,
  input  logic [31:0]                 in_time_ms,
  input  logic [2:0]                  in_actor_code,
  input  logic [2:0]                  in_channel_code,
  input  logic [3:0]                  in_phase_code,
  input  logic                        in_redacted_flag,
  input  logic                        in_background_flag,
  input  logic [31:0]                 in_after_sequence,
  input  logic [6:0]                  in_max_events,
  output logic                        cmd_valid,
  output selu_pkg::cmd_t              cmd,
  input  logic                        cmd_pop
);

  selu_pkg::cmd_t                     q_mem [selu_pkg::QUEUE_DEPTH];
  logic [selu_pkg::QPTR_W-1:0]        wr_ptr_r;
  logic [selu_pkg::QPTR_W-1:0]        rd_ptr_r;
  logic [selu_pkg::QCNT_W-1:0]        count_r;
  logic [selu_pkg::QCNT_W-1:0]        count_nxt;
  logic                               push;
  logic                               codes_ok;
  selu_pkg::cmd_t                     new_cmd;

  // Classify the incoming word
  always_comb begin
    codes_ok = (in_actor_code <= selu_pkg::ACTOR_MAX) &&
               (in_channel_code <= selu_pkg::CHANNEL_MAX) &&
               (in_phase_code <= selu_pkg::PHASE_MAX);
    new_cmd.time_ms    = in_time_ms;
    new_cmd.tag        = {in_background_flag, in_redacted_flag, in_phase_code,
                          in_channel_code, in_actor_code[1:0]};
    new_cmd.seq_floor  = in_after_sequence;
    new_cmd.max_events = in_max_events;
    if (in_func == selu_pkg::FUNC_READ) begin
      new_cmd.kind = selu_pkg::KIND_READ;
    end else if (codes_ok) begin
      new_cmd.kind = selu_pkg::KIND_APPEND;
    end else begin
      new_cmd.kind = selu_pkg::KIND_REJECT;
    end
  end

  // Queue handshake
  assign busy      = (count_r == selu_pkg::QCNT_W'(selu_pkg::QUEUE_DEPTH));
  assign push      = start && !busy;
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !cmd_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && cmd_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= new_cmd;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == selu_pkg::QPTR_W'(selu_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_r + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr_r <= (rd_ptr_r == selu_pkg::QPTR_W'(selu_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= selu_pkg::QCNT_W'(selu_pkg::QUEUE_DEPTH))
    else $error("command queue overfilled");

  a_pop_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("pop from empty command queue");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !cmd_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not grow on push");

endmodule

// ===== hw/rtl/selu_back.sv =====
// ----------------------------------------------------------------------------
// selu_back: log execution
// Pops classified commands, appends entries into the ring memory and walks the
// ring from oldest to newest for reads, emitting a result word for each command and each matching entry.
// ----------------------------------------------------------------------------
module selu_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  input  selu_pkg::cmd_t        cmd,
  output logic                  cmd_pop,
  output logic                  out_valid,
  output logic [1:0]            out_status,
  output logic [31:0]           out_event_sequence,
  output logic [31:0]           out_event_time_ms,
  output logic [1:0]            out_event_actor,
  output logic [2:0]            out_event_channel,
  output logic [3:0]            out_event_phase,
  output logic                  out_event_redacted,
  output logic                  out_event_background,
  output logic [31:0]           out_newest_sequence,
  output logic                  out_history_lost,
  output logic                  out_last_of_run,
  output logic [31:0]           out_dropped_total
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_ISSUE,
    ST_RD_EVAL,
    ST_FINISH
  } state_t;

  state_t                          state_r;
  selu_pkg::entry_t                mem [selu_pkg::LOG_DEPTH];
  selu_pkg::entry_t                rd_data_r;
  selu_pkg::entry_t                hold_r;
  logic                            hold_valid_r;
  selu_pkg::cmd_t                  cmd_r;
  logic [31:0]                     last_seq_r;
  logic [selu_pkg::IDX_W-1:0]      wr_idx_r;
  logic [selu_pkg::CNT_W-1:0]      count_r;
  logic [31:0]                     dropped_r;
  logic [selu_pkg::IDX_W-1:0]      rd_ptr_r;
  logic [selu_pkg::CNT_W-1:0]      walk_i_r;
  logic [selu_pkg::MAXE_W-1:0]     emitted_n_r;
  logic                            lost_r;
  logic                            out_valid_r;
  selu_pkg::result_t               out_r;

  logic [31:0]                     seq_inc;
  logic [31:0]                     seq_nxt;
  logic                            is_full;
  logic [31:0]                     dropped_nxt;
  logic [selu_pkg::SUM_W-1:0]      start_sum;
  logic [selu_pkg::IDX_W-1:0]      start_idx;
  logic                            app_we;
  logic                            rd_en;
  logic                            hit;
  logic                            lost_calc;
  logic                            lost_now;
  logic [selu_pkg::CNT_W-1:0]      i_inc;
  logic [selu_pkg::MAXE_W-1:0]     n_inc;
  logic                            walk_done;
  selu_pkg::entry_t                app_ent;

  // Append arithmetic: next sequence skips zero, drop on overwrite
  always_comb begin
    seq_inc     = last_seq_r + 32'd1;
    seq_nxt     = (seq_inc == '0) ? 32'd1 : seq_inc;
    is_full     = (count_r == selu_pkg::CNT_W'(selu_pkg::LOG_DEPTH));
    dropped_nxt = is_full ? dropped_r + 32'd1 : dropped_r;
    app_ent.seq     = seq_nxt;
    app_ent.time_ms = cmd.time_ms;
    app_ent.tag     = cmd.tag;
  end

  // Oldest slot: write index minus entry count, modulo depth
  always_comb begin
    start_sum = selu_pkg::SUM_W'(wr_idx_r) + selu_pkg::SUM_W'(selu_pkg::LOG_DEPTH)
              - selu_pkg::SUM_W'(count_r);
    if (start_sum >= selu_pkg::SUM_W'(selu_pkg::LOG_DEPTH)) begin
      start_sum = start_sum - selu_pkg::SUM_W'(selu_pkg::LOG_DEPTH);
    end
    start_idx = start_sum[selu_pkg::IDX_W-1:0];
  end

  // Walk evaluation on the registered read word
  always_comb begin
    hit       = (rd_data_r.seq > cmd_r.seq_floor);
    lost_calc = (cmd_r.seq_floor != '0) && (rd_data_r.seq > 32'd1) &&
                (cmd_r.seq_floor < rd_data_r.seq - 32'd1);
    lost_now  = (walk_i_r == '0) ? lost_calc : lost_r;
    i_inc     = walk_i_r + 1'b1;
    n_inc     = emitted_n_r + 1'b1;
    walk_done = (i_inc == count_r) || (hit && (n_inc == cmd_r.max_events));
  end

  assign cmd_pop = (state_r == ST_IDLE) && cmd_valid;
  assign app_we  = cmd_pop && (cmd.kind == selu_pkg::KIND_APPEND);
  assign rd_en   = (state_r == ST_RD_ISSUE);

  // Ring memory, registered read
  always_ff @(posedge clk) begin
    if (app_we) begin
      mem[wr_idx_r] <= app_ent;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  // Sequencer, log state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      last_seq_r   <= '0;
      wr_idx_r     <= '0;
      count_r      <= '0;
      dropped_r    <= '0;
      hold_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (cmd_valid) begin
            unique case (cmd.kind)
              selu_pkg::KIND_REJECT: begin
                out_valid_r <= 1'b1;
                out_r <= selu_pkg::make_result(selu_pkg::STATUS_REJECTED, '0,
                                               last_seq_r, 1'b0, 1'b1, dropped_r);
              end
              selu_pkg::KIND_APPEND: begin
                last_seq_r <= seq_nxt;
                wr_idx_r   <= (wr_idx_r == selu_pkg::IDX_W'(selu_pkg::LOG_DEPTH - 1)) ?
                              '0 : wr_idx_r + 1'b1;
                if (!is_full) begin
                  count_r <= count_r + 1'b1;
                end
                dropped_r   <= dropped_nxt;
                out_valid_r <= 1'b1;
                out_r <= selu_pkg::make_result(selu_pkg::STATUS_APPENDED, app_ent,
                                               seq_nxt, 1'b0, 1'b1, dropped_nxt);
              end
              selu_pkg::KIND_READ: begin
                cmd_r <= cmd;
                if ((cmd.max_events == '0) || (count_r == '0)) begin
                  out_valid_r <= 1'b1;
                  out_r <= selu_pkg::make_result(selu_pkg::STATUS_NONE, '0,
                                                 last_seq_r, 1'b0, 1'b1, dropped_r);
                end else begin
                  rd_ptr_r     <= start_idx;
                  walk_i_r     <= '0;
                  emitted_n_r  <= '0;
                  hold_valid_r <= 1'b0;
                  lost_r       <= 1'b0;
                  state_r      <= ST_RD_ISSUE;
                end
              end
              default: ;
            endcase
          end
        end

        ST_RD_ISSUE: begin
          state_r <= ST_RD_EVAL;
        end

        // A hit is held back one step so the final one can carry last_of_run
        ST_RD_EVAL: begin
          lost_r <= lost_now;
          if (hit) begin
            if (hold_valid_r) begin
              out_valid_r <= 1'b1;
              out_r <= selu_pkg::make_result(selu_pkg::STATUS_EVENT, hold_r,
                                             last_seq_r, lost_now, 1'b0, dropped_r);
            end
            hold_r       <= rd_data_r;
            hold_valid_r <= 1'b1;
            emitted_n_r  <= n_inc;
          end
          walk_i_r <= i_inc;
          if (walk_done) begin
            state_r <= ST_FINISH;
          end else begin
            rd_ptr_r <= (rd_ptr_r == selu_pkg::IDX_W'(selu_pkg::LOG_DEPTH - 1)) ?
                        '0 : rd_ptr_r + 1'b1;
            state_r  <= ST_RD_ISSUE;
          end
        end

        ST_FINISH: begin
          out_valid_r <= 1'b1;
          if (hold_valid_r) begin
            out_r <= selu_pkg::make_result(selu_pkg::STATUS_EVENT, hold_r,
                                           last_seq_r, lost_r, 1'b1, dropped_r);
          end else begin
            out_r <= selu_pkg::make_result(selu_pkg::STATUS_NONE, '0,
                                           last_seq_r, lost_r, 1'b1, dropped_r);
          end
          hold_valid_r <= 1'b0;
          state_r      <= ST_IDLE;
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Result ports
  assign out_valid            = out_valid_r;
  assign out_status           = out_r.status;
  assign out_event_sequence   = out_r.ent.seq;
  assign out_event_time_ms    = out_r.ent.time_ms;
  assign out_event_actor      = out_r.ent.tag[1:0];
  assign out_event_channel    = out_r.ent.tag[4:2];
  assign out_event_phase      = out_r.ent.tag[8:5];
  assign out_event_redacted   = out_r.ent.tag[9];
  assign out_event_background = out_r.ent.tag[10];
  assign out_newest_sequence  = out_r.newest;
  assign out_history_lost     = out_r.lost;
  assign out_last_of_run      = out_r.last;
  assign out_dropped_total    = out_r.dropped;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= selu_pkg::CNT_W'(selu_pkg::LOG_DEPTH))
    else $error("entry count above log depth");

  a_no_drop_when_room: assert property (@(posedge clk) disable iff (!rst_n)
    (app_we && !is_full) |=> $stable(dropped_r))
    else $error("drop counted while log had room");

  a_walk_under_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD_ISSUE) |-> (emitted_n_r < cmd_r.max_events))
    else $error("read walk continued past max_events");

  a_append_seq_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == selu_pkg::STATUS_APPENDED)) |->
    (out_event_sequence != '0))
    else $error("append stamped with sequence zero");

endmodule

// ===== hw/rtl/sequenced_event_ring_log_unit.sv =====
// ----------------------------------------------------------------------------
// sequenced_event_ring_log_unit: circular event log with sequence numbers
// Fixed-depth trace buffer that stamps appended events and returns stored
// events newer than a given sequence, oldest first.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_* with start high; the word is taken on a clock
//   edge where busy is low. func 0 appends, func 1 reads.
//   Result channel: each result word is on out_* for exactly one cycle with
//   out_valid high; out_last_of_run marks the final word of an input word.
//   The receiver cannot stall the block, so no result is ever held back.
// Timing:
//   A two-word command queue sits between intake and the execution sequencer.
//   An append or rejected append is queued and its result is registered when
//   the sequencer pops it; the sequencer retires one append per cycle while
//   no read is in progress. A read occupies the sequencer while it walks
//   k >= 1 ring entries (at most the entry count); each entry takes a memory
//   read step and an evaluate step on the single ring memory port.
//   A read with max_events 0 or on an empty log is answered without a walk.
//   busy rises only while the command queue is full.
// Reset:
//   rst_n low clears the queue, the sequence counter, the fill count and the
//   drop counter. Ring memory contents are not cleared; only written entries
//   are ever read.
// ----------------------------------------------------------------------------
module sequenced_event_ring_log_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [31:0] in_time_ms,
  input  logic [2:0]  in_actor_code,
  input  logic [2:0]  in_channel_code,
  input  logic [3:0]  in_phase_code,
  input  logic        in_redacted_flag,
  input  logic        in_background_flag,
  input  logic [31:0] in_after_sequence,
  input  logic [6:0]  in_max_events,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_event_sequence,
  output logic [31:0] out_event_time_ms,
  output logic [1:0]  out_event_actor,
  output logic [2:0]  out_event_channel,
  output logic [3:0]  out_event_phase,
  output logic        out_event_redacted,
  output logic        out_event_background,
  output logic [31:0] out_newest_sequence,
  output logic        out_history_lost,
  output logic        out_last_of_run,
  output logic [31:0] out_dropped_total
);

  logic           cmd_valid;
  logic           cmd_pop;
  selu_pkg::cmd_t cmd;

  // Intake and classification
  selu_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_func            (in_func),
    .in_time_ms         (in_time_ms),
    .in_actor_code      (in_actor_code),
    .in_channel_code    (in_channel_code),
    .in_phase_code      (in_phase_code),
    .in_redacted_flag   (in_redacted_flag),
    .in_background_flag (in_background_flag),
    .in_after_sequence  (in_after_sequence),
    .in_max_events      (in_max_events),
    .cmd_valid          (cmd_valid),
    .cmd                (cmd),
    .cmd_pop            (cmd_pop)
  );

  // Execution against the ring
  selu_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd_valid            (cmd_valid),
    .cmd                  (cmd),
    .cmd_pop              (cmd_pop),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_event_sequence   (out_event_sequence),
    .out_event_time_ms    (out_event_time_ms),
    .out_event_actor      (out_event_actor),
    .out_event_channel    (out_event_channel),
    .out_event_phase      (out_event_phase),
    .out_event_redacted   (out_event_redacted),
    .out_event_background (out_event_background),
    .out_newest_sequence  (out_newest_sequence),
    .out_history_lost     (out_history_lost),
    .out_last_of_run      (out_last_of_run),
    .out_dropped_total    (out_dropped_total)
  );

endmodule
